>>> src/single_float_add_sub_mul_div_unit_defines.svh
// ---------------------------------------------------------------------------
// Single float unit assertion macros
// Shared concurrent check forms for the floating-point unit.
// ---------------------------------------------------------------------------
`ifndef SINGLE_FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`define SINGLE_FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH

// same-cycle implication
`define SFU_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg) \
lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication
`define SFU_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
else $error(msg);

`endif

>>> src/sfu_pkg.sv
// ---------------------------------------------------------------------------
// Single float unit package
// Operation codes, word constants and the pipeline request record.
// ---------------------------------------------------------------------------
package sfu_pkg;

	localparam logic [1:0] FuncAdd = 2'd0;
	localparam logic [1:0] FuncSub = 2'd1;
	localparam logic [1:0] FuncMul = 2'd2;
	localparam logic [1:0] FuncDiv = 2'd3;

	localparam logic [31:0] SignBit  = 32'h8000_0000;
	localparam logic [31:0] MagMask  = 32'h7FFF_FFFF;
	localparam logic [31:0] QnanWord = 32'h7FC0_0000;
	localparam logic [7:0]  ExpMax   = 8'hFF;

	localparam int DivIters        = 28;
	localparam int DivStepsDefault = 2;

	typedef struct packed {
		logic [1:0]         func;
		logic               done;
		logic [31:0]        word;
		logic               sign;
		logic signed [10:0] expo;
		logic               eff_sub;
		logic [28:0]        mant;
		logic [27:0]        aux;
		logic [24:0]        rem;
		logic [23:0]        dvs;
	} item_t;

	function automatic logic is_nan(input logic [31:0] w);
		return (w[30:23] == ExpMax) && (w[22:0] != 23'd0);
	endfunction

	function automatic logic [23:0] sig_of(input logic [31:0] w);
		return {1'b1, w[22:0]};
	endfunction

endpackage

>>> src/sfu_decode.sv
// ---------------------------------------------------------------------------
// Single float unit decode stage
// Special operands, operand swap and alignment, exponent setup.
// ---------------------------------------------------------------------------
module sfu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [1:0]          func,
	input  logic [31:0]         operand_a,
	input  logic [31:0]         operand_b,
	output logic                out_vld,
	output sfu_pkg::item_t      out_item
);

	sfu_pkg::item_t     it;
	sfu_pkg::item_t     item_s1;
	logic               vld_s1;
	logic [31:0]        bx;
	logic [31:0]        big;
	logic [31:0]        sml;
	logic [7:0]         eb;
	logic [7:0]         es;
	logic [7:0]         sh;
	logic [27:0]        ms_full;
	logic signed [10:0] ea_s;
	logic signed [10:0] eb_s;
	logic               sgn;

	always_comb begin
		it      = '0;
		it.func = func;
		bx      = ((func == sfu_pkg::FuncSub) && (operand_b != 32'd0)) ?
		          (operand_b ^ sfu_pkg::SignBit) : operand_b;
		if ((operand_a & sfu_pkg::MagMask) >= (bx & sfu_pkg::MagMask)) begin
			big = operand_a;
			sml = bx;
		end else begin
			big = bx;
			sml = operand_a;
		end
		eb      = big[30:23];
		es      = sml[30:23];
		sh      = eb - es;
		ms_full = {sfu_pkg::sig_of(sml), 4'b0000};
		ea_s    = $signed({3'b000, operand_a[30:23]});
		eb_s    = $signed({3'b000, operand_b[30:23]});
		sgn     = operand_a[31] ^ operand_b[31];
		unique case (func)
			sfu_pkg::FuncAdd, sfu_pkg::FuncSub: begin
				it.done = 1'b1;
				priority if (operand_a == 32'd0) begin
					it.word = bx;
				end else if (bx == 32'd0) begin
					it.word = operand_a;
				end else if ((eb == sfu_pkg::ExpMax) && (es == sfu_pkg::ExpMax)) begin
					priority if (sfu_pkg::is_nan(big))  it.word = big;
					else if (sfu_pkg::is_nan(sml))      it.word = sml;
					else if (big[31] != sml[31])        it.word = sfu_pkg::QnanWord;
					else                                it.word = big;
				end else if (eb == sfu_pkg::ExpMax) begin
					it.word = big;
				end else if (es == sfu_pkg::ExpMax) begin
					it.word = sml;
				end else begin
					it.done    = 1'b0;
					it.sign    = big[31];
					it.expo    = $signed({3'b000, eb});
					it.mant    = {1'b0, sfu_pkg::sig_of(big), 4'b0000};
					it.aux     = (sh >= 8'd28) ? 28'd0 : (ms_full >> sh);
					it.eff_sub = big[31] ^ sml[31];
				end
			end
			sfu_pkg::FuncMul: begin
				it.done = 1'b1;
				priority if (sfu_pkg::is_nan(operand_a)) begin
					it.word = operand_a;
				end else if (sfu_pkg::is_nan(operand_b)) begin
					it.word = operand_b;
				end else if ((operand_a == 32'd0) || (operand_b == 32'd0)) begin
					it.word = 32'd0;
				end else if (operand_a[30:23] == sfu_pkg::ExpMax) begin
					it.word = {sgn, operand_a[30:0]};
				end else if (operand_b[30:23] == sfu_pkg::ExpMax) begin
					it.word = {sgn, operand_b[30:0]};
				end else begin
					it.done = 1'b0;
					it.sign = sgn;
					it.expo = ea_s + eb_s - 11'sd127;
					it.mant = {5'd0, sfu_pkg::sig_of(operand_a)};
					it.dvs  = sfu_pkg::sig_of(operand_b);
				end
			end
			sfu_pkg::FuncDiv: begin
				it.done = 1'b1;
				priority if (sfu_pkg::is_nan(operand_a)) begin
					it.word = operand_a;
				end else if (sfu_pkg::is_nan(operand_b)) begin
					it.word = operand_b;
				end else if ((operand_a[30:23] == sfu_pkg::ExpMax) &&
				             (operand_b[30:23] == sfu_pkg::ExpMax)) begin
					it.word = sfu_pkg::QnanWord;
				end else if (operand_b == 32'd0) begin
					it.word = sfu_pkg::QnanWord;
				end else if (operand_a == 32'd0) begin
					it.word = 32'd0;
				end else if (operand_a[30:23] == sfu_pkg::ExpMax) begin
					it.word = {sgn, operand_a[30:0]};
				end else if (operand_b[30:23] == sfu_pkg::ExpMax) begin
					it.word = 32'd0;
				end else begin
					it.done = 1'b0;
					it.sign = sgn;
					it.expo = ea_s - eb_s + 11'sd127;
					it.rem  = {1'b0, sfu_pkg::sig_of(operand_a)};
					it.dvs  = sfu_pkg::sig_of(operand_b);
				end
			end
			default: it.done = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= it;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

>>> src/sfu_arith.sv
// ---------------------------------------------------------------------------
// Single float unit arithmetic stage
// Significand add or subtract, and the significand product.
// ---------------------------------------------------------------------------
module sfu_arith (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  sfu_pkg::item_t in_item,
	output logic           out_vld,
	output sfu_pkg::item_t out_item
);

	sfu_pkg::item_t it;
	sfu_pkg::item_t item_s2;
	logic           vld_s2;
	logic [47:0]    prod;

	always_comb begin
		it   = in_item;
		prod = in_item.mant[23:0] * in_item.dvs;
		if (!in_item.done) begin
			unique case (in_item.func)
				sfu_pkg::FuncAdd, sfu_pkg::FuncSub: begin
					it.mant = in_item.eff_sub ? (in_item.mant - {1'b0, in_item.aux}) :
					          (in_item.mant + {1'b0, in_item.aux});
				end
				sfu_pkg::FuncMul: it.mant = prod[47:19];
				sfu_pkg::FuncDiv: it.mant = in_item.mant;
				default:          it.mant = in_item.mant;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= it;
		end
	end

	assign out_vld  = vld_s2;
	assign out_item = item_s2;

endmodule

>>> src/sfu_div_stage.sv
// ---------------------------------------------------------------------------
// Single float unit divider stage
// STEPS restoring quotient steps; other requests pass through.
// ---------------------------------------------------------------------------
`include "single_float_add_sub_mul_div_unit_defines.svh"

module sfu_div_stage #(
	parameter int STEPS = sfu_pkg::DivStepsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  sfu_pkg::item_t in_item,
	output logic           out_vld,
	output sfu_pkg::item_t out_item
);

	sfu_pkg::item_t it;
	sfu_pkg::item_t item_s3;
	logic           vld_s3;
	logic [24:0]    r;
	logic [27:0]    q;
	logic           div_live;
	logic [24:0]    dvs_twice;

	always_comb begin
		it = in_item;
		r  = in_item.rem;
		q  = in_item.aux;
		for (int i = 0; i < STEPS; i++) begin
			if (r >= {1'b0, in_item.dvs}) begin
				r = r - {1'b0, in_item.dvs};
				q = {q[26:0], 1'b1};
			end else begin
				q = {q[26:0], 1'b0};
			end
			r = {r[23:0], 1'b0};
		end
		if (!in_item.done && (in_item.func == sfu_pkg::FuncDiv)) begin
			it.rem = r;
			it.aux = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= it;
		end
	end

	assign out_vld  = vld_s3;
	assign out_item = item_s3;

	assign div_live  = out_vld && !out_item.done && (out_item.func == sfu_pkg::FuncDiv);
	assign dvs_twice = {out_item.dvs, 1'b0};

	`SFU_ASSERT_NOW(rem_bound_a, clk, arst_n, div_live, out_item.rem < dvs_twice, "divider remainder out of range")
	`SFU_ASSERT_NOW(dvs_norm_a, clk, arst_n, div_live, out_item.dvs[23], "divisor lost its hidden one")
	`SFU_ASSERT_NEXT(hold_a, clk, arst_n, !en && out_vld, out_vld && $stable(out_item), "stage moved while stalled")

endmodule

>>> src/sfu_round.sv
// ---------------------------------------------------------------------------
// Single float unit normalise and round stages
// Leading-one alignment, then +8 rounding, range checks and packing.
// ---------------------------------------------------------------------------
module sfu_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  sfu_pkg::item_t in_item,
	output logic           out_vld,
	output logic [31:0]    out_word
);

	typedef struct packed {
		logic               done;
		logic [31:0]        word;
		logic               sign;
		logic signed [10:0] expo;
		logic [28:0]        m;
		logic               rnd;
		logic               ren;
	} norm_t;

	norm_t              n;
	norm_t              norm_s4;
	logic               vld_s4;
	logic [4:0]         lz;
	logic               found;
	logic [28:0]        m2;
	logic signed [10:0] e2;
	logic [31:0]        w;
	logic [31:0]        word_s5;
	logic               vld_s5;

	always_comb begin
		lz    = 5'd0;
		found = 1'b0;
		for (int i = 27; i >= 0; i--) begin
			if (!found && in_item.mant[i]) begin
				lz    = 5'(27 - i);
				found = 1'b1;
			end
		end
		n.done = in_item.done;
		n.word = in_item.word;
		n.sign = in_item.sign;
		n.expo = in_item.expo;
		n.m    = in_item.mant;
		n.rnd  = 1'b1;
		n.ren  = 1'b1;
		unique case (in_item.func)
			sfu_pkg::FuncAdd, sfu_pkg::FuncSub: begin
				if (!in_item.eff_sub) begin
					n.ren = 1'b0;
					if (in_item.mant[28]) begin
						n.expo = in_item.expo + 11'sd1;
						n.m    = {1'b0, in_item.mant[28:1]};
					end else begin
						n.rnd = 1'b0;
					end
				end else if (in_item.mant == 29'd0) begin
					n.done = 1'b1;
					n.word = 32'd0;
				end else begin
					n.m    = {1'b0, in_item.mant[27:0] << lz};
					n.expo = in_item.expo - $signed({6'd0, lz});
					if (n.expo <= 11'sd0) begin
						n.done = 1'b1;
						n.word = 32'd0;
					end
				end
			end
			sfu_pkg::FuncMul: begin
				if (in_item.mant[28]) begin
					n.expo = in_item.expo + 11'sd1;
					n.m    = {1'b0, in_item.mant[28:1]};
				end
			end
			sfu_pkg::FuncDiv: begin
				if (in_item.aux[27]) begin
					n.m = {1'b0, in_item.aux};
				end else begin
					n.m    = {in_item.aux, 1'b0};
					n.expo = in_item.expo - 11'sd1;
				end
			end
			default: n.done = 1'b1;
		endcase
		if (in_item.done) begin
			n.done = 1'b1;
			n.word = in_item.word;
		end
	end

	always_comb begin
		m2 = norm_s4.rnd ? (norm_s4.m + 29'd8) : norm_s4.m;
		e2 = norm_s4.expo;
		if (norm_s4.ren && m2[28]) begin
			m2 = {1'b0, m2[28:1]};
			e2 = norm_s4.expo + 11'sd1;
		end
		priority if (norm_s4.done) w = norm_s4.word;
		else if (e2 >= 11'sd255)   w = {norm_s4.sign, sfu_pkg::ExpMax, 23'd0};
		else if (e2 < 11'sd0)      w = 32'd0;
		else                       w = {norm_s4.sign, e2[7:0], m2[26:4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s4 <= n;
			word_s5 <= w;
		end
	end

	assign out_vld  = vld_s5;
	assign out_word = word_s5;

endmodule

>>> src/single_float_add_sub_mul_div_unit.sv
// ---------------------------------------------------------------------------
// Single float add, subtract, multiply and divide unit
// Pipelined single-precision arithmetic with one result per request.
// ---------------------------------------------------------------------------
// channel   dir  tdata                          tuser
// s_axis    in   [31:0] operand_a, [63:32] b    [1:0] func
// m_axis    out  [31:0] result_word             -
//
// One request enters per cycle while m_axis is not stalled. The divider
// chain of 28/DIV_STEPS stages sets the depth.
// Reset empties the pipeline; no clearing pass.
// A stall at m_axis freezes every stage together.
// ---------------------------------------------------------------------------
module single_float_add_sub_mul_div_unit #(
	parameter int DIV_STEPS = sfu_pkg::DivStepsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
	input  logic [1:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // result_word
);

	localparam int DivStages = sfu_pkg::DivIters / DIV_STEPS;

	logic           en;
	logic           vld_d1;
	sfu_pkg::item_t item_d1;
	logic           chain_vld  [DivStages+1];
	sfu_pkg::item_t chain_item [DivStages+1];

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	sfu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_axis_tvalid),
		.func      (s_axis_tuser),
		.operand_a (s_axis_tdata[31:0]),
		.operand_b (s_axis_tdata[63:32]),
		.out_vld   (vld_d1),
		.out_item  (item_d1)
	);

	sfu_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_d1),
		.in_item  (item_d1),
		.out_vld  (chain_vld[0]),
		.out_item (chain_item[0])
	);

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		sfu_div_stage #(.STEPS(DIV_STEPS)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (chain_vld[g]),
			.in_item  (chain_item[g]),
			.out_vld  (chain_vld[g+1]),
			.out_item (chain_item[g+1])
		);
	end

	sfu_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (chain_vld[DivStages]),
		.in_item  (chain_item[DivStages]),
		.out_vld  (m_axis_tvalid),
		.out_word (m_axis_tdata)
	);

endmodule

>>> dv/single_float_add_sub_mul_div_unit_test.sv
// ---------------------------------------------------------------------------
// Single float unit regression
// Drives add, subtract, multiply and divide requests through the stream
// ports under varied idling and back-pressure, predicts every result word
// with a bit-accurate model of the datapath and compares in order.
// ---------------------------------------------------------------------------
class sfu_scoreboard;
	logic [31:0] pending[$];
	int errors;

	function logic [31:0] pack_word(logic s, int e, logic [31:0] m);
		if (e >= 255) begin
			e = 255;
			m = 0;
		end
		return {s, e[7:0], m[26:4]};
	endfunction

	function logic [31:0] shift_carry(logic [31:0] m, ref int e);
		for (int k = 0; k < 4 && (m & 32'hF000_0000) != 0; k++) begin
			e++;
			m = m >> 1;
		end
		return m;
	endfunction

	function logic [31:0] add_words(logic [31:0] a, logic [31:0] b);
		logic [31:0] big, sml, mb, ms, m;
		int eb, es, e, sh;
		if (a == 0) return b;
		if (b == 0) return a;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = big[30:23];
		es = sml[30:23];
		if (eb == 255 && es == 255) begin
			if (sfu_pkg::is_nan(big)) return big;
			if (sfu_pkg::is_nan(sml)) return sml;
			if (big[31] ^ sml[31]) return sfu_pkg::QnanWord;
		end
		if (eb == 255) return big;
		if (es == 255) return sml;
		mb = {4'd0, 1'b1, big[22:0], 4'd0};
		ms = {4'd0, 1'b1, sml[22:0], 4'd0};
		sh = eb - es;
		ms = (sh >= 28) ? 0 : (ms >> sh);
		e = eb;
		if (big[31] ^ sml[31]) begin
			m = mb - ms;
			if (m == 0) return 0;
			for (int k = 0; k < 28 && m[27] == 0; k++) begin
				e--;
				m = m << 1;
			end
			if (e <= 0) return 0;
			m += 8;
			m = shift_carry(m, e);
		end else begin
			m = mb + ms;
			if ((m & 32'hF000_0000) != 0) begin
				e++;
				m = (m >> 1) + 8;
			end
		end
		return pack_word(big[31], e, m);
	endfunction

	function logic [31:0] mul_words(logic [31:0] a, logic [31:0] b);
		logic [31:0] fa, fb, m;
		logic s;
		int e;
		s = a[31] ^ b[31];
		if (sfu_pkg::is_nan(a)) return a;
		if (sfu_pkg::is_nan(b)) return b;
		if (a == 0 || b == 0) return 0;
		if (a[30:23] == 255) return {s, a[30:0]};
		if (b[30:23] == 255) return {s, b[30:0]};
		fa = {4'd0, 1'b1, a[22:0], 4'd0};
		fb = {8'd0, 1'b1, b[22:0]};
		m = 0;
		e = int'(a[30:23]) + int'(b[30:23]) - 127;
		for (int i = 0; i < 24; i++) begin
			if (fb[i]) m += fa;
			if (i < 23) m = m >> 1;
		end
		m = shift_carry(m, e);
		m += 8;
		m = shift_carry(m, e);
		if (e >= 255) return pack_word(s, 255, 0);
		if (e < 0) return 0;
		return pack_word(s, e, m);
	endfunction

	function logic [31:0] div_words(logic [31:0] a, logic [31:0] b);
		logic [31:0] fa, fb, q;
		logic s;
		int e;
		s = a[31] ^ b[31];
		if (sfu_pkg::is_nan(a)) return a;
		if (sfu_pkg::is_nan(b)) return b;
		if (a[30:23] == 255 && b[30:23] == 255) return sfu_pkg::QnanWord;
		if (b == 0) return sfu_pkg::QnanWord;
		if (a == 0) return 0;
		if (a[30:23] == 255) return {s, a[30:0]};
		if (b[30:23] == 255) return 0;
		fa = {8'd0, 1'b1, a[22:0]};
		fb = {8'd0, 1'b1, b[22:0]};
		q = 0;
		e = int'(a[30:23]) - int'(b[30:23]) + 127;
		for (int i = 0; i < 28; i++) begin
			if (fa >= fb) begin
				fa -= fb;
				q++;
			end
			fa = fa << 1;
			if (i < 27) q = q << 1;
		end
		for (int i = 0; i < 28 && q != 0 && q[27] == 0; i++) begin
			e--;
			q = q << 1;
		end
		q += 8;
		q = shift_carry(q, e);
		if (e >= 255) return pack_word(s, 255, 0);
		if (e < 0) return 0;
		return pack_word(s, e, q);
	endfunction

	function void note_request(logic [1:0] func, logic [31:0] a, logic [31:0] b);
		logic [31:0] r;
		case (func)
			sfu_pkg::FuncAdd: r = add_words(a, b);
			sfu_pkg::FuncSub: r = (b == 0) ? a : add_words(a, b ^ sfu_pkg::SignBit);
			sfu_pkg::FuncMul: r = mul_words(a, b);
			default: r = div_words(a, b);
		endcase
		pending.push_back(r);
	endfunction

	function void check_result(logic [31:0] got);
		logic [31:0] want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$display("%0t: result_word expected %h actual %h", $time, want, got);
			errors++;
		end
	endfunction
endclass

module single_float_add_sub_mul_div_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;

	sfu_scoreboard result_board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	single_float_add_sub_mul_div_unit i_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			result_board.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
		if (m_axis_tvalid && m_axis_tready)
			result_board.check_result(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (!s_axis_tvalid && result_board.pending.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_axis_tready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(logic [1:0] func, logic [31:0] a, logic [31:0] b);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= func;
		s_axis_tdata <= {b, a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(9))
			0: w[30:23] = 8'hFF;
			1: w[30:23] = 8'h00;
			2: w = $urandom_range(1) ? 32'h0 : 32'h8000_0000;
			3: w[30:23] = 8'(127 + $urandom_range(6) - 3);
			4: w[30:23] = $urandom_range(1) ? 8'hFE : 8'h01;
			default: w[30:23] = 8'(100 + $urandom_range(55));
		endcase
		return w;
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		logic [31:0] a, b;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			a = random_word();
			b = ($urandom_range(3) == 0) ? (a ^ ($urandom_range(1) << 31) ^ $urandom_range(7))
				: random_word();
			send_request(2'($urandom_range(3)), a, b);
		end
	endtask

	logic [31:0] edge_words[12] = '{32'h0, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
		32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
		32'h0000_0001, 32'h007F_FFFF, 32'h4040_0000};

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_request(2'(i % 4), edge_words[2 * i], edge_words[2 * i + 1]);
		send_request(sfu_pkg::FuncSub, 32'h7F80_0000, 32'h7F80_0000);
		send_request(sfu_pkg::FuncDiv, 32'h7F80_0000, 32'hFF80_0000);
		send_request(sfu_pkg::FuncDiv, 32'h3F80_0000, 32'h0);
		send_request(sfu_pkg::FuncDiv, 32'h0, 32'h4000_0000);
		send_request(sfu_pkg::FuncDiv, 32'h4000_0000, 32'h7F80_0000);
		send_request(sfu_pkg::FuncMul, 32'h7F80_0000, 32'hBF80_0000);
		send_request(sfu_pkg::FuncAdd, 32'h4B80_0000, 32'h3F80_0000);
		send_request(sfu_pkg::FuncSub, 32'h3F80_0001, 32'h3F80_0000);
		send_request(sfu_pkg::FuncSub, 32'h0080_0000, 32'h0000_0001);
		send_request(sfu_pkg::FuncMul, 32'h7F00_0000, 32'h4000_0000);
		send_request(sfu_pkg::FuncMul, 32'h0080_0000, 32'h0080_0000);
		send_request(sfu_pkg::FuncAdd, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
		send_request(sfu_pkg::FuncDiv, 32'h3FFF_FFFF, 32'h3F80_0001);
		send_request(sfu_pkg::FuncAdd, 32'h7FC0_0000, 32'hFFC0_0001);
		random_phase(450, 0, 0);
		random_phase(350, 66, 0);
		random_phase(350, 0, 66);
		hold_off = 200;
		random_phase(350, 0, 0);
		random_phase(330, 21, 21);
		s_axis_tvalid <= 0;
		recv_stall_pct = 0;
		while (result_board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (result_board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
